[rtl/core/h264ns_pkg.sv]
// Shared types, constants and helpers for the H.264 Annex B NAL splitter.
// No dependencies; imported by h264ns_parse and h264_annexb_nal_splitter.
package h264ns_pkg;

  localparam int SIZE_BITS = 24;
  localparam int HDR_BITS  = 8;
  localparam int TYPE_BITS = 5;
  localparam int SLEN_BITS = 3;

  // result word: header, type, start length, unit size, frame size
  localparam int OUT_FIELD_BITS = HDR_BITS + TYPE_BITS + SLEN_BITS + 2 * SIZE_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic [SIZE_BITS-1:0] nal_size_t;
  typedef logic [HDR_BITS-1:0]  nal_hdr_t;
  typedef logic [TYPE_BITS-1:0] nal_type_t;
  typedef logic [SLEN_BITS-1:0] sc_len_t;

  localparam nal_size_t SIZE_MAX = '1;

  localparam nal_type_t NAL_IDR = 5'd5;
  localparam nal_type_t NAL_SEI = 5'd6;
  localparam nal_type_t NAL_SPS = 5'd7;
  localparam nal_type_t NAL_PPS = 5'd8;

  localparam sc_len_t SC_LEN3 = 3'd3;
  localparam sc_len_t SC_LEN4 = 3'd4;

  typedef struct packed {
    nal_hdr_t  nal_header;
    nal_type_t nal_type;
    sc_len_t   start_length;
    nal_size_t nal_size;
    logic      frame_done;
    nal_size_t frame_size;
    logic      key_frame;
  } nal_res_t;

  // saturating add of two size counts
  function automatic nal_size_t sat_add(input nal_size_t a, input nal_size_t b);
    logic [SIZE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_BITS] ? SIZE_MAX : s[SIZE_BITS-1:0];
  endfunction

endpackage

[rtl/core/h264ns_parse.sv]
// Start-code detector, unit byte counter and frame grouper; one byte per cycle while byte_fire is high.
// Depends on h264ns_pkg.
module h264ns_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_fire,
  input  h264ns_pkg::nal_hdr_t data_byte,
  input  logic                 end_of_stream,
  output logic                 res_valid,
  output h264ns_pkg::nal_res_t res
);
  import h264ns_pkg::*;

  logic [23:0] hist_r, hist_nxt;
  logic        inside_r, inside_nxt;
  nal_size_t   cnt_r, cnt_nxt;
  sc_len_t     slen_r, slen_nxt;
  logic        hpend_r, hpend_nxt;
  nal_hdr_t    hdr_r, hdr_nxt;
  nal_size_t   facc_r, facc_nxt;

  logic        sc;
  sc_len_t     len;
  nal_size_t   len_m1;
  nal_size_t   cnt_inc;
  logic        emit;
  nal_size_t   emit_size;
  nal_hdr_t    emit_hdr;
  nal_type_t   ntype;
  nal_size_t   acc_sum;

  always_comb begin
    hist_nxt   = hist_r;
    inside_nxt = inside_r;
    cnt_nxt    = cnt_r;
    slen_nxt   = slen_r;
    hpend_nxt  = hpend_r;
    hdr_nxt    = hdr_r;
    facc_nxt   = facc_r;
    emit       = 1'b0;
    emit_size  = '0;
    emit_hdr   = hdr_r;
    res        = '0;

    sc      = (data_byte == 8'h01) && (hist_r[15:0] == 16'h0000);
    len     = (hist_r[23:16] == 8'h00) ? SC_LEN4 : SC_LEN3;
    len_m1  = nal_size_t'(len - 3'd1);
    cnt_inc = sat_add(cnt_r, nal_size_t'(1));

    if (sc) begin
      if (inside_r) begin
        // zeros of the new start code were counted into the old unit
        emit = 1'b1;
        if (cnt_r == SIZE_MAX) begin
          emit_size = SIZE_MAX;
        end else if (cnt_r >= len_m1) begin
          emit_size = cnt_r - len_m1;
        end else begin
          emit_size = '0;
        end
      end
      inside_nxt = 1'b1;
      cnt_nxt    = nal_size_t'(len);
      slen_nxt   = len;
      hpend_nxt  = 1'b1;
      hdr_nxt    = '0;
    end else if (inside_r) begin
      if (hpend_r) begin
        hdr_nxt   = data_byte;
        hpend_nxt = 1'b0;
        emit_hdr  = data_byte;
      end
      cnt_nxt = cnt_inc;
      if (end_of_stream) begin
        emit      = 1'b1;
        emit_size = cnt_inc;
      end
    end

    ntype   = emit_hdr[TYPE_BITS-1:0];
    acc_sum = sat_add(facc_r, emit_size);

    if (emit) begin
      res.nal_header   = emit_hdr;
      res.nal_type     = ntype;
      res.start_length = slen_r;
      res.nal_size     = emit_size;
      case (ntype) inside
        NAL_SEI, NAL_SPS, NAL_PPS: begin
          facc_nxt = acc_sum;
        end
        default: begin
          res.frame_done = 1'b1;
          res.frame_size = acc_sum;
          res.key_frame  = (ntype == NAL_IDR);
          facc_nxt       = '0;
        end
      endcase
    end

    if (end_of_stream) begin
      // unit state back to reset; frame total carries over
      hist_nxt   = '1;
      inside_nxt = 1'b0;
      cnt_nxt    = '0;
      slen_nxt   = SC_LEN3;
      hpend_nxt  = 1'b0;
      hdr_nxt    = '0;
    end else begin
      hist_nxt = {hist_r[15:0], data_byte};
    end

    res_valid = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= '1;
      inside_r <= 1'b0;
      cnt_r    <= '0;
      slen_r   <= SC_LEN3;
      hpend_r  <= 1'b0;
      hdr_r    <= '0;
      facc_r   <= '0;
    end else if (byte_fire) begin
      hist_r   <= hist_nxt;
      inside_r <= inside_nxt;
      cnt_r    <= cnt_nxt;
      slen_r   <= slen_nxt;
      hpend_r  <= hpend_nxt;
      hdr_r    <= hdr_nxt;
      facc_r   <= facc_nxt;
    end
  end

  // a header is only awaited inside an open unit
  a_hpend_inside: assert property (@(posedge clk) disable iff (!rst_n)
    hpend_r |-> inside_r)
    else $error("header pending outside a unit");

  // an open unit has at least its start code counted
  a_cnt_min: assert property (@(posedge clk) disable iff (!rst_n)
    inside_r |-> (cnt_r >= nal_size_t'(SC_LEN3)))
    else $error("open unit count below start code length");

  // a start code with a closed stream history cannot follow end of stream
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_fire && end_of_stream) |=> (!inside_r && hist_r == 24'hFFFFFF))
    else $error("unit state not cleared after end of stream");

endmodule

[rtl/core/h264_annexb_nal_splitter.sv]
// H.264 Annex B NAL splitter, top level: byte input stream, result stream
// through a two-word output buffer. Depends on h264ns_pkg and h264ns_parse.
//
// The block takes one stream byte per clock on in_tdata, with in_tlast marking
// the last byte of a stream, and hunts for 00 00 01 and 00 00 00 01 start codes.
// Each time a NAL unit ends (next start code, or end of stream) one result word
// comes out: header byte, type, start-code length and the unit size counted
// from the first start-code byte. SEI/SPS/PPS units are added into a running
// frame size; any other unit closes the frame: out_tlast goes high, the frame
// total rides in the top field of out_tdata, and out_tuser flags an IDR key
// frame. Bytes before the first start code are dropped; sizes saturate at
// 2^24-1. The frame total survives end of stream, the start-code history does
// not. Throughput is one byte per clock while in_tready is high: all parsing
// state updates in a single register stage. A two-word output buffer lets the
// input keep flowing while one result waits; in_tready drops only once a
// second result is parked behind a stalled sink.
module h264_annexb_nal_splitter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // byte input
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,  // [7:0] data_byte
  input  logic                                  in_tlast,  // end_of_stream
  // result output
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [7:0] nal_header, [12:8] nal_type, [15:13] start_length,
  // [39:16] nal_size, [63:40] frame_size
  output logic [h264ns_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  output logic                                  out_tlast, // frame_done
  output logic                                  out_tuser  // key_frame
);
  import h264ns_pkg::*;

  logic     in_fire;
  logic     out_fire;
  logic     res_valid;
  nal_res_t res;

  nal_res_t out_r;
  logic     out_valid_r;
  nal_res_t skid_r;
  logic     skid_valid_r;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  h264ns_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_fire     (in_fire),
    .data_byte     (in_tdata),
    .end_of_stream (in_tlast),
    .res_valid     (res_valid),
    .res           (res)
  );

  // two-entry output queue: out_r is the head, skid_r the tail
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // input is held off here, so nothing new arrives
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else begin
      if (in_fire && res_valid) begin
        if (!out_valid_r || out_fire) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  // fields packed from the low bit up, zero filled to whole bytes
  assign out_tdata  = OUT_DATA_BITS'({out_r.frame_size, out_r.nal_size,
                                      out_r.start_length, out_r.nal_type,
                                      out_r.nal_header});
  assign out_tlast  = out_r.frame_done;
  assign out_tuser  = out_r.key_frame;

  // tail is only occupied behind an occupied head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without head word");

  // a key frame flag only comes with a frame close
  a_key_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("key frame on a unit that does not close a frame");

  // start length is 3 or 4 on every result
  a_slen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_r.start_length == SC_LEN3 || out_r.start_length == SC_LEN4))
    else $error("bad start code length");

  // frame size reads zero unless the word closes a frame
  a_fsize_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_r.frame_size == '0))
    else $error("frame size set on a unit inside a frame");

  // a result parked in the tail moves to the head when the head drains
  a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_fire) |=> (out_valid_r && !skid_valid_r))
    else $error("skid word not promoted");

endmodule

[tb/testbench.sv]
// Self-checking testbench for h264_annexb_nal_splitter: byte stream in, NAL
// unit results out, checked against an in-bench predictor of unit/frame sizes.
// Depends on h264ns_pkg and the splitter RTL; needs nothing else.
module testbench;
  import h264ns_pkg::*;

  // start-code marker byte and a plain (non-parameter-set) slice type
  localparam logic [7:0] SC_MARK = 8'h01;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam nal_type_t NAL_SLICE = 5'd1;

  localparam int N_RANDOM = 1150;   // rough count of random stream bytes
  localparam int QUIET_WORDS = 150;   // tail of the run driven with no idling
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 20;   // settle time for the core and the two-word out buffer
  localparam int MAX_PRINTS = 40;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks start-code history, the open unit and the running
  // frame total, and keeps the results the block still owes us.
  // --------------------------------------------------------------------------
  class nal_scoreboard;
    logic [23:0] recent_bytes;  // last three bytes, newest in the low byte
    bit unit_open;
    nal_size_t unit_bytes;
    sc_len_t unit_sc_len;
    bit want_header;
    nal_hdr_t unit_hdr;
    nal_size_t frame_bytes;
    nal_res_t owed_q[$];
    int errors;

    function new();
      drop_unit();
      frame_bytes = '0;
      errors = 0;
    endfunction

    function void drop_unit();
      recent_bytes = '1;
      unit_open = 1'b0;
      unit_bytes = '0;
      unit_sc_len = SC_LEN3;
      want_header = 1'b0;
      unit_hdr = '0;
    endfunction

    function nal_size_t clamp_sum(nal_size_t a, nal_size_t b);
      logic [SIZE_BITS:0] s;
      s = (SIZE_BITS + 1)'(a) + (SIZE_BITS + 1)'(b);
      return (s > SIZE_MAX) ? SIZE_MAX : s[SIZE_BITS-1:0];
    endfunction

    function void finish_unit(nal_size_t size);
      nal_res_t r;
      r.nal_header = unit_hdr;
      r.nal_type = unit_hdr[TYPE_BITS-1:0];
      r.start_length = unit_sc_len;
      r.nal_size = size;
      frame_bytes = clamp_sum(frame_bytes, size);
      if (r.nal_type inside {NAL_SEI, NAL_SPS, NAL_PPS}) begin
        r.frame_done = 1'b0;
        r.frame_size = '0;
        r.key_frame = 1'b0;
      end else begin
        r.frame_done = 1'b1;
        r.frame_size = frame_bytes;
        r.key_frame = (r.nal_type == NAL_IDR);
        frame_bytes = '0;
      end
      owed_q.push_back(r);
    endfunction

    // one accepted input word
    function void note_byte(logic [7:0] b, logic eos);
      bit is_sc;
      sc_len_t len;
      nal_size_t zeros;
      nal_size_t trimmed;
      is_sc = (b == SC_MARK) && (recent_bytes[15:0] == {ZERO_BYTE, ZERO_BYTE});
      len = (recent_bytes[23:16] == ZERO_BYTE) ? SC_LEN4 : SC_LEN3;
      zeros = nal_size_t'(len) - nal_size_t'(1);
      if (is_sc) begin
        if (unit_open) begin
          // the new start code's zeros were already counted into this unit
          if (unit_bytes == SIZE_MAX)
            trimmed = SIZE_MAX;
          else if (unit_bytes >= zeros)
            trimmed = unit_bytes - zeros;
          else
            trimmed = '0;
          finish_unit(trimmed);
        end
        unit_open = 1'b1;
        unit_bytes = nal_size_t'(len);
        unit_sc_len = len;
        want_header = 1'b1;
        unit_hdr = '0;
      end else if (unit_open) begin
        if (want_header) begin
          unit_hdr = b;
          want_header = 1'b0;
        end
        unit_bytes = clamp_sum(unit_bytes, nal_size_t'(1));
        if (eos)
          finish_unit(unit_bytes);
      end
      // end of stream wipes history and the open unit, frame total survives
      if (eos)
        drop_unit();
      else
        recent_bytes = {recent_bytes[15:0], b};
    endfunction

    task report(string what);
      if (errors < MAX_PRINTS)
        $display("ERROR @%0t: %s", $time, what);
      errors++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task check_result(nal_res_t got);
      nal_res_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result with none owed: hdr 0x%0h size %0d",
                         got.nal_header, got.nal_size));
        return;
      end
      want = owed_q.pop_front();
      cmp_field("nal_header", 32'(got.nal_header), 32'(want.nal_header));
      cmp_field("nal_type", 32'(got.nal_type), 32'(want.nal_type));
      cmp_field("start_length", 32'(got.start_length), 32'(want.start_length));
      cmp_field("nal_size", 32'(got.nal_size), 32'(want.nal_size));
      cmp_field("frame_done", 32'(got.frame_done), 32'(want.frame_done));
      cmp_field("frame_size", 32'(got.frame_size), 32'(want.frame_size));
      cmp_field("key_frame", 32'(got.key_frame), 32'(want.key_frame));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and its ports
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic in_tlast;         // end_of_stream
  logic out_tvalid;
  logic out_tready;
  // [7:0] nal_header, [12:8] nal_type, [15:13] start_length,
  // [39:16] nal_size, [63:40] frame_size
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic out_tlast;        // frame_done
  logic out_tuser;        // key_frame

  h264_annexb_nal_splitter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  nal_scoreboard sb = new();
  bit quiet_tail = 1'b0;   // set for the last stretch: no idling either side
  nal_res_t seen_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stream builder: a queue of words, each a byte plus its end-of-stream flag
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] data;
    logic last;
  } stream_word_t;

  stream_word_t stream_q[$];

  function automatic void put(logic [7:0] b, logic last = 1'b0);
    stream_word_t w;
    w.data = b;
    w.last = last;
    stream_q.push_back(w);
  endfunction

  // payload bytes lean toward zeros and ones so stray start codes turn up
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 9))
      0, 1: return ZERO_BYTE;
      2: return SC_MARK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void put_unit(bit four, nal_hdr_t hdr, int body_len, bit close_stream);
    if (four)
      put(ZERO_BYTE);
    put(ZERO_BYTE);
    put(ZERO_BYTE);
    put(SC_MARK);
    put(hdr, close_stream && body_len == 0);
    for (int i = 0; i < body_len; i++)
      put(payload_byte(), close_stream && i == body_len - 1);
  endfunction

  function automatic nal_hdr_t random_header();
    nal_type_t t;
    case ($urandom_range(0, 9))
      0, 1: t = NAL_IDR;
      2: t = NAL_SEI;
      3: t = NAL_SPS;
      4: t = NAL_PPS;
      5, 6, 7: t = NAL_SLICE;
      default: t = 5'($urandom_range(0, 31));
    endcase
    return {3'($urandom_range(0, 7)), t};
  endfunction

  task automatic build_stream();
    int base;
    int n;
    // junk ahead of the first start code: dropped
    put(8'hAB); put(ZERO_BYTE); put(SC_MARK);
    // SPS behind a 4-byte start code, then PPS and SEI: frame accumulates
    put(ZERO_BYTE); put(ZERO_BYTE); put(ZERO_BYTE); put(SC_MARK); put(8'h67);
    put(ZERO_BYTE); put(ZERO_BYTE); put(SC_MARK); put(8'h68);
    put(ZERO_BYTE); put(ZERO_BYTE); put(ZERO_BYTE); put(SC_MARK); put(8'h06);
    // IDR closes the frame as a key frame
    put(ZERO_BYTE); put(ZERO_BYTE); put(SC_MARK); put(8'h65); put(8'hFF);
    // start code on the last byte: IDR reported, empty unit discarded
    put(ZERO_BYTE); put(ZERO_BYTE); put(SC_MARK, 1'b1);
    // end of stream with no unit open
    put(ZERO_BYTE, 1'b1);
    // extreme header, unit ended by end of stream
    put(ZERO_BYTE); put(ZERO_BYTE); put(SC_MARK); put(8'hFF); put(8'h80, 1'b1);
    put(ZERO_BYTE); put(ZERO_BYTE); put(SC_MARK); put(ZERO_BYTE, 1'b1);

    base = stream_q.size();
    while (stream_q.size() < base + N_RANDOM) begin
      case ($urandom_range(0, 9))
        0: begin
          // noise, sometimes closing a stream mid-way
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++)
            put(payload_byte(), i == n - 1 && $urandom_range(0, 3) == 0);
        end
        1: begin
          // start code that never completes
          put(ZERO_BYTE);
          if ($urandom_range(0, 1))
            put(ZERO_BYTE);
          put(8'($urandom_range(2, 255)));
        end
        default: begin
          n = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 16);
          put_unit($urandom_range(0, 1) == 1, random_header(), n,
                   $urandom_range(0, 9) == 0);
        end
      endcase
    end
    // flush whatever unit is still open
    put_unit(1'b1, {3'd3, NAL_SLICE}, 2, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: one word per handshake, random idle bursts, quiet tail
  // --------------------------------------------------------------------------
  task automatic drive_stream();
    int idle_odds;
    idle_odds = 0;
    for (int i = 0; i < stream_q.size(); i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_odds = 0;     // stretch with no gaps
          1: idle_odds = 3;
          default: idle_odds = 10;
        endcase
      end
      if (i >= stream_q.size() - QUIET_WORDS)
        quiet_tail = 1'b1;
      if (!quiet_tail && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= stream_q[i].data;
      in_tlast <= stream_q[i].last;
      @(posedge clk);
      while (!in_tready)
        @(posedge clk);
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sink: random stall bursts on out_tready, none in the quiet tail
  // --------------------------------------------------------------------------
  initial begin
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: results are checked before the same edge's input word is noted;
  // an input's result can never appear on the edge that accepts it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen_res.nal_header = out_tdata[7:0];
        seen_res.nal_type = out_tdata[12:8];
        seen_res.start_length = out_tdata[15:13];
        seen_res.nal_size = out_tdata[39:16];
        seen_res.frame_size = out_tdata[63:40];
        seen_res.frame_done = out_tlast;
        seen_res.key_frame = out_tuser;
        sb.check_result(seen_res);
      end
      if (in_tvalid && in_tready)
        sb.note_byte(in_tdata, in_tlast);
    end
  end

  // watchdog: ends the run if neither side moves a word for too long
  initial begin
    int stuck;
    stuck = 0;
    wait (rst_n);
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stuck = 0;
      else
        stuck++;
    end
    $display("ERROR: no handshake for %0d cycles, %0d results owed",
             WATCHDOG_LIMIT, sb.owed_q.size());
    $display("FAIL h264_annexb_nal_splitter");
    $finish;
  end

  // main sequence: reset once, stream, drain, verdict
  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    build_stream();
    drive_stream();
    while (sb.owed_q.size() != 0)
      @(posedge clk);
    // catch any stray extra result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS h264_annexb_nal_splitter");
    else
      $display("FAIL h264_annexb_nal_splitter");
    $finish;
  end

endmodule
